// ===== rtl/lcgrr_pkg.sv =====
// lcgrr_pkg: shared types and constants for the rotated lcg generator
// no dependencies
`default_nettype none
package lcgrr_pkg;
	localparam logic [31:0] LCG_MULT = 32'd9579501;
	localparam logic [31:0] LCG_INC  = 32'd37;
	localparam int          LCG_ROT  = 16;

	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_INT   = 2'd1,
		OP_FLOAT = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_DIV,
		ST_NORM,
		ST_ROUND,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/lcg_rotate_random_generator_top.sv =====
// lcg_rotate_random_generator_top: rotated lcg with raw, modulo and float draws
// depends on lcgrr_pkg
//
// channel | direction | signals
// in      | sink      | in_valid, in_stall, opcode, operand
// out     | source    | out_valid, out_stall, value
//
// a load completes in ST_IDLE; a raw draw passes through ST_ADV to ST_OUT, where it waits on out_stall
// an integer draw advances the seed in ST_ADV and, unless the divisor is zero, then forms
// one quotient bit per cycle in a shared shift/subtract unit, 32 steps
// a float draw of a nonzero value uses the same shift unit, which normalizes one bit a cycle
// arst_n clears the seed and the control state; payload registers are not reset
// in_stall is high whenever an item is in work or a result waits on out_stall
`default_nettype none
module lcg_rotate_random_generator_top
	import lcgrr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] operand,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      value
);
	state_t      state_q, state_d;
	logic [31:0] seed_q;
	op_t         op_q;
	logic [31:0] div_q;
	// shared shift register: dividend bits during division, mantissa during normalize
	logic [31:0] sh_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic [7:0]  exp_q;
	logic [31:0] value_q;

	logic [31:0] prod;
	logic [31:0] adv;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [24:0] mant_r;
	logic        rnd_up;

	assign prod  = seed_q * LCG_MULT + LCG_INC;
	assign adv   = {prod[LCG_ROT-1:0], prod[31:LCG_ROT]};
	// restoring division step
	assign trial = {rem_q[31:0], sh_q[31]};
	assign diff  = trial - {1'b0, div_q};
	// rounding of the normalized word: keep 24 bits, guard at bit 7, sticky below
	assign rnd_up = sh_q[7] && ((|sh_q[6:0]) || sh_q[8]);
	assign mant_r = {1'b0, sh_q[31:8]} + {24'd0, rnd_up};

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign value     = value_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op_t'(opcode) == OP_LOAD) ? ST_IDLE : ST_ADV;
				end
			end
			ST_ADV: begin
				unique case (op_q)
					OP_INT:   state_d = (div_q == 32'd0) ? ST_OUT : ST_DIV;
					OP_FLOAT: state_d = (adv == 32'd0) ? ST_OUT : ST_NORM;
					default:  state_d = ST_OUT;
				endcase
			end
			ST_DIV: begin
				if (cnt_q == 6'd31) begin
					state_d = ST_OUT;
				end
			end
			ST_NORM: begin
				if (sh_q[31]) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= 32'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid && op_t'(opcode) == OP_LOAD) begin
				seed_q <= operand;
			end else if (state_q == ST_ADV) begin
				seed_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q  <= op_t'(opcode);
				div_q <= operand;
			end
			ST_ADV: begin
				sh_q    <= adv;
				rem_q   <= 33'd0;
				cnt_q   <= 6'd0;
				exp_q   <= 8'd126; // value in [2^31,2^32) scales to exponent -1
				value_q <= (op_q == OP_RAW) ? adv : 32'd0;
			end
			ST_DIV: begin
				sh_q  <= {sh_q[30:0], 1'b0};
				rem_q <= diff[32] ? trial : diff;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					value_q <= diff[32] ? trial[31:0] : diff[31:0];
				end
			end
			ST_NORM: begin
				if (!sh_q[31]) begin
					sh_q  <= {sh_q[30:0], 1'b0};
					exp_q <= exp_q - 8'd1;
				end
			end
			ST_ROUND: begin
				if (mant_r[24]) begin
					value_q <= {1'b0, exp_q + 8'd1, 23'd0};
				end else begin
					value_q <= {1'b0, exp_q, mant_r[22:0]};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/lcgrr_checker.sv =====
// lcgrr_checker: port-level checks on the generator, bound to its top level
// depends on lcgrr_pkg and lcg_rotate_random_generator_top
`default_nettype none
module lcgrr_checker
	import lcgrr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  opcode,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] value
);
	// a stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("result changed under stall");
	// no input transfer while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted with result pending");
	// a draw never yields a result in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");
	// a load leaves the block ready
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
		else $error("load left block busy");
endmodule

bind lcg_rotate_random_generator_top lcgrr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall), .value(value)
);
`default_nettype wire
